/* hdl/bme_pkg.sv */
// bme_pkg: shared types and constants of the mode encoder
// no dependencies
`default_nettype none

package bme_pkg;

    localparam int CHAR_W        = 7;
    localparam int LEN_W         = 9;
    localparam int SLOTS         = 4;
    localparam int SLOT_W        = 2;
    localparam int QUEUE_DEPTH   = 4;
    localparam int BUFFER_SIZE_D = 256;

    localparam logic [CHAR_W-1:0] MODE_CHAR_RST = 7'h21;
    localparam logic [CHAR_W-1:0] CTRL_LIMIT    = 7'h20;
    localparam logic [CHAR_W-1:0] CTRL_OFFSET   = 7'h20;

    // one classified input: up to four encoded characters
    typedef struct packed {
        logic [SLOTS-1:0][CHAR_W-1:0] chars;
        logic [SLOTS-1:0][LEN_W-1:0]  lens;
        logic [SLOT_W-1:0]            last_slot;
        logic                         has_char;
        logic                         end_run;
    } t_desc;

endpackage

`default_nettype wire

/* hdl/bme_front.sv */
// bme_front: accepts input characters, holds mode and fill state, and
// expands each request into a descriptor of encoded characters; uses bme_pkg
`default_nettype none

module bme_front
    import bme_pkg::*;
#(
    parameter int BUFFER_SIZE = BUFFER_SIZE_D
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CHAR_W-1:0] i_cfg_data,
    input  wire logic              i_accept,
    input  wire logic [CHAR_W-1:0] i_in_char,
    input  wire logic              i_last_in,
    output t_desc                  o_desc,
    output logic                   o_desc_valid
);

    localparam int FW = $clog2(BUFFER_SIZE + 1);
    localparam int LW = (FW + 1 > LEN_W) ? FW + 1 : LEN_W;
    localparam logic [LW-1:0] BS = LW'(BUFFER_SIZE);

    logic [CHAR_W-1:0] r_mode_char;
    logic              r_pm;
    logic [FW-1:0]     r_fill;
    logic              n_pm;
    logic [FW-1:0]     n_fill;

    logic [LW-1:0]     f;
    logic              p;
    logic [2:0]        n;

    always_comb begin
        f = LW'(r_fill);
        p = r_pm;
        n = '0;
        o_desc = '0;
        if (i_in_char >= CTRL_LIMIT) begin
            if (!p) begin
                if (f < BS) begin
                    f = f + 1'b1;
                    o_desc.chars[n[SLOT_W-1:0]] = r_mode_char;
                    o_desc.lens[n[SLOT_W-1:0]]  = f[LEN_W-1:0];
                    n = n + 1'b1;
                end
                p = 1'b1;
            end
            // printable characters need two free places
            if (f + 1'b1 < BS) begin
                f = f + 1'b1;
                o_desc.chars[n[SLOT_W-1:0]] = i_in_char;
                o_desc.lens[n[SLOT_W-1:0]]  = f[LEN_W-1:0];
                n = n + 1'b1;
                if (i_in_char == r_mode_char) begin
                    f = f + 1'b1;
                    o_desc.chars[n[SLOT_W-1:0]] = i_in_char;
                    o_desc.lens[n[SLOT_W-1:0]]  = f[LEN_W-1:0];
                    n = n + 1'b1;
                end
            end
        end else begin
            if (p) begin
                if (f < BS) begin
                    f = f + 1'b1;
                    o_desc.chars[n[SLOT_W-1:0]] = r_mode_char;
                    o_desc.lens[n[SLOT_W-1:0]]  = f[LEN_W-1:0];
                    n = n + 1'b1;
                end
                p = 1'b0;
            end
            if (f < BS) begin
                f = f + 1'b1;
                o_desc.chars[n[SLOT_W-1:0]] = i_in_char + CTRL_OFFSET;
                o_desc.lens[n[SLOT_W-1:0]]  = f[LEN_W-1:0];
                n = n + 1'b1;
            end
        end
        if (i_last_in && p) begin
            if (f < BS) begin
                f = f + 1'b1;
                o_desc.chars[n[SLOT_W-1:0]] = r_mode_char;
                o_desc.lens[n[SLOT_W-1:0]]  = f[LEN_W-1:0];
                n = n + 1'b1;
            end
            p = 1'b0;
        end
        // empty end marker carries the final length
        if (n == 3'd0) begin
            o_desc.lens[0] = f[LEN_W-1:0];
        end
        o_desc.last_slot = (n == 3'd0) ? '0 : SLOT_W'(n - 1'b1);
        o_desc.has_char  = (n != 3'd0);
        o_desc.end_run   = i_last_in;
        o_desc_valid     = i_accept && ((n != 3'd0) || i_last_in);
        n_pm   = i_last_in ? 1'b0 : p;
        n_fill = i_last_in ? '0 : f[FW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_char <= MODE_CHAR_RST;
            r_pm        <= 1'b0;
            r_fill      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_mode_char <= i_cfg_data;
            end
            if (i_accept) begin
                r_pm   <= n_pm;
                r_fill <= n_fill;
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/bme_queue.sv */
// bme_queue: short descriptor queue between front and back
// uses bme_pkg
`default_nettype none

module bme_queue
    import bme_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_wr_en,
    input  wire t_desc i_wr_data,
    input  wire logic  i_rd_en,
    output t_desc      o_rd_data,
    output logic       o_full,
    output logic       o_empty
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_desc         r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW:0]   r_count;

    logic wr_ok;
    logic rd_ok;

    assign o_full    = (r_count == (PW + 1)'(QUEUE_DEPTH));
    assign o_empty   = (r_count == '0);
    assign wr_ok     = i_wr_en && !o_full;
    assign rd_ok     = i_rd_en && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_ok) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (wr_ok && !rd_ok) begin
                r_count <= r_count + 1'b1;
            end else if (rd_ok && !wr_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/bme_back.sv */
// bme_back: steps through the characters of the head descriptor, one per pop
// uses bme_pkg
`default_nettype none

module bme_back
    import bme_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_desc             i_desc,
    input  wire logic              i_q_empty,
    input  wire logic              i_pop,
    output logic                   o_deq,
    output logic [CHAR_W-1:0]      o_out_char,
    output logic                   o_has_char,
    output logic                   o_end_of_run,
    output logic [LEN_W-1:0]       o_buffer_length
);

    logic [SLOT_W-1:0] r_slot;
    logic              at_last;
    logic              take;

    assign at_last         = (r_slot == i_desc.last_slot);
    assign take            = i_pop && !i_q_empty;
    assign o_deq           = take && at_last;
    assign o_out_char      = i_desc.chars[r_slot];
    assign o_has_char      = i_desc.has_char;
    assign o_end_of_run    = i_desc.end_run && at_last;
    assign o_buffer_length = i_desc.lens[r_slot];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else if (take) begin
            r_slot <= at_last ? '0 : r_slot + 1'b1;
        end
    end

endmodule

`default_nettype wire

/* hdl/bic_mode_encoder_unit.sv */
// bic_mode_encoder_unit: top level of the control/printable mode encoder
// depends on bme_pkg, bme_front, bme_queue, bme_back
//
// usage
//   input channel: i_push / o_full, payload i_in_char and i_last_in; a request
//   is taken at a clock edge with i_push high and o_full low
//   result channel: o_empty / i_pop, payload o_out_char, o_has_char,
//   o_end_of_run, o_buffer_length; the oldest result is shown while o_empty
//   is low and is taken at an edge with i_pop high
//   config: i_cfg_we / i_cfg_data load the mode character; the user must
//   load it only while idle, which the block itself does not enforce
// throughput: one input request per cycle while the queue has room; each
//   request yields 0 to 4 results, delivered one per cycle while i_pop is
//   high, so the sustained rate is set by the result port
// reset: mode character back to '!', control mode, fill count 0, queue empty
// stall: while i_pop is low the result is held; the four-entry descriptor
//   queue keeps taking requests until it fills, then o_full rises
`default_nettype none

module bic_mode_encoder_unit
    import bme_pkg::*;
#(
    parameter int BUFFER_SIZE = BUFFER_SIZE_D
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // configuration
    input  wire logic              i_cfg_we,
    input  wire logic [CHAR_W-1:0] i_cfg_data,
    // input requests
    input  wire logic              i_push,
    output logic                   o_full,
    input  wire logic [CHAR_W-1:0] i_in_char,
    input  wire logic              i_last_in,
    // results
    output logic                   o_empty,
    input  wire logic              i_pop,
    output logic [CHAR_W-1:0]      o_out_char,
    output logic                   o_has_char,
    output logic                   o_end_of_run,
    output logic [LEN_W-1:0]       o_buffer_length
);

    t_desc front_desc;
    t_desc head_desc;
    logic  front_valid;
    logic  q_full;
    logic  q_empty;
    logic  deq;
    logic  accept;

    // request accepted on push with queue room
    assign accept  = i_push && !q_full;
    assign o_full  = q_full;
    assign o_empty = q_empty;

    // front: mode and fill bookkeeping, expansion into a descriptor
    bme_front #(
        .BUFFER_SIZE (BUFFER_SIZE)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (accept),
        .i_in_char    (i_in_char),
        .i_last_in    (i_last_in),
        .o_desc       (front_desc),
        .o_desc_valid (front_valid)
    );

    // decoupling queue, requests with no result never enter it
    bme_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (front_valid),
        .i_wr_data (front_desc),
        .i_rd_en   (deq),
        .o_rd_data (head_desc),
        .o_full    (q_full),
        .o_empty   (q_empty)
    );

    // back: serializes the head descriptor onto the result port
    bme_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_desc          (head_desc),
        .i_q_empty       (q_empty),
        .i_pop           (i_pop),
        .o_deq           (deq),
        .o_out_char      (o_out_char),
        .o_has_char      (o_has_char),
        .o_end_of_run    (o_end_of_run),
        .o_buffer_length (o_buffer_length)
    );

endmodule

`default_nettype wire
